[sv/htd_pkg.sv]
// Shared types and constants for the hold trigger with decay block.
package htd_pkg;

   // Field widths fixed by the block's interface.
   localparam int unsigned TimeWidth   = 24;   // Q8.16 seconds
   localparam int unsigned FactorWidth = 16;   // Q8.8 factor
   localparam int unsigned CsrIdxWidth = 3;
   localparam int unsigned AccWidth    = 40;   // widest truncated product
   localparam int unsigned ProdWidth   = 48;   // 32 x 16 multiplier output

   // Configuration register indexes.
   localparam logic [CsrIdxWidth-1:0] CsrHoldThreshold = 3'd0;
   localparam logic [CsrIdxWidth-1:0] CsrDecayDelay    = 3'd1;
   localparam logic [CsrIdxWidth-1:0] CsrDecayRate     = 3'd2;
   localparam logic [CsrIdxWidth-1:0] CsrActuatedBoost = 3'd3;
   localparam logic [CsrIdxWidth-1:0] CsrUseDilation   = 3'd4;
   localparam logic [CsrIdxWidth-1:0] CsrOneShot       = 3'd5;

   // Register reset values.
   localparam logic [TimeWidth-1:0]   ThresholdReset = 24'h01_0000;  // 1.0 s
   localparam logic [TimeWidth-1:0]   DelayReset     = 24'h00_0000;
   localparam logic [FactorWidth-1:0] UnityFactor    = 16'h0100;     // 1.0
   localparam logic [TimeWidth-1:0]   TimeMax        = 24'hFF_FFFF;

   // Result codes.
   typedef enum logic [1:0] {
      TRIG_NONE      = 2'd0,
      TRIG_ONGOING   = 2'd1,
      TRIG_TRIGGERED = 2'd2
   } trig_state_type;

   // Sequencer states.
   typedef enum logic [2:0] {
      S_IDLE,
      S_SCALE,
      S_FACTOR,
      S_UPDATE,
      S_RESULT
   } seq_state_type;

endpackage

[sv/hold_trigger_with_decay.sv]
// Hold trigger with decay: sequencer around one shared 32x16 multiplier.
//
// Usage: each transfer on the req_ channel is one tick, carrying the actuated
// flag, the tick's elapsed time (Q8.16 seconds) and a dilation factor (Q8.8).
// Every tick produces exactly one transfer on the rsp_ channel with the
// trigger state (none, ongoing or triggered).
// The block works on one tick at a time. After a tick is taken, req_ready
// stays low while the sequencer steps through one multiply for the dilation
// scaling, one multiply for the boost or decay rate, the held-time add or
// subtract with its clamp, and the threshold compare as the result is loaded
// into the output register. req_ready rises again only once that load is
// done, so no new tick is taken before the last one is through.
// The result sits in an output register, so a new tick may be taken while an
// earlier result still waits. If the receiver stalls long enough that the
// next result is finished while the register is still full, the sequencer
// holds in its last step until the register frees, and no tick is taken.
// Configuration is written through csr_we/csr_index/csr_wdata by the user
// only while the block is idle (not enforced); unused indexes are ignored.
// Synchronous reset restores the register defaults (threshold 1.0 s, no
// delay, decay rate and boost 1.0, dilation and one-shot off), clears the
// held time, the release counter and the trigger history, and empties the
// output register.
module hold_trigger_with_decay (
   input  logic                                clock,
   input  logic                                reset,
   // Tick input channel.
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic                                req_actuated,
   input  logic [htd_pkg::TimeWidth-1:0]       req_tick_time,
   input  logic [htd_pkg::FactorWidth-1:0]     req_dilation,
   // Result channel.
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [1:0]                          rsp_trigger_state,
   // Configuration write port.
   input  logic                                csr_we,
   input  logic [htd_pkg::CsrIdxWidth-1:0]     csr_index,
   input  logic [htd_pkg::TimeWidth-1:0]       csr_wdata
);

   // Configuration registers.
   logic [htd_pkg::TimeWidth-1:0]   hold_threshold_ff;
   logic [htd_pkg::TimeWidth-1:0]   decay_delay_ff;
   logic [htd_pkg::FactorWidth-1:0] decay_rate_ff;
   logic [htd_pkg::FactorWidth-1:0] actuated_boost_ff;
   logic                            use_dilation_ff;
   logic                            one_shot_ff;

   // Trigger state carried from tick to tick.
   logic [htd_pkg::TimeWidth-1:0]   held_time_ff;
   logic [htd_pkg::TimeWidth-1:0]   release_time_ff;
   logic                            boost_pending_ff;
   logic                            was_triggered_ff;

   // Latched tick and working values.
   logic                            act_ff;
   logic [htd_pkg::TimeWidth-1:0]   tick_ff;
   logic [htd_pkg::FactorWidth-1:0] dil_ff;
   logic [htd_pkg::AccWidth-1:0]    acc_ff;
   logic                            do_decay_ff;

   // Output register.
   logic                            rsp_valid_ff;
   htd_pkg::trig_state_type         rsp_state_ff;

   // Sequencer.
   htd_pkg::seq_state_type          state_ff;
   htd_pkg::seq_state_type          state_in;

   // Shared multiplier.
   logic [31:0]                     mul_a;
   logic [htd_pkg::FactorWidth-1:0] mul_b;
   logic [htd_pkg::ProdWidth-1:0]   mul_prod;
   logic [htd_pkg::AccWidth-1:0]    mul_q;

   // Sequencer outputs.
   logic                            out_free;
   logic                            out_load;

   // Datapath intermediates.
   logic [htd_pkg::TimeWidth:0]     release_sum;
   logic [htd_pkg::TimeWidth-1:0]   release_sat;
   logic [htd_pkg::AccWidth:0]      grow_sum;
   logic                            trig_now;

   // The output register frees when it is empty or being emptied this cycle.
   assign out_free = !rsp_valid_ff || rsp_ready;

   // ---------------------------------------------------------------------
   // Next-state logic.
   // ---------------------------------------------------------------------
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         htd_pkg::S_IDLE: begin
            if (req_valid) state_in = htd_pkg::S_SCALE;
         end
         htd_pkg::S_SCALE:  state_in = htd_pkg::S_FACTOR;
         htd_pkg::S_FACTOR: state_in = htd_pkg::S_UPDATE;
         htd_pkg::S_UPDATE: state_in = htd_pkg::S_RESULT;
         htd_pkg::S_RESULT: begin
            if (out_free) state_in = htd_pkg::S_IDLE;
         end
         default: state_in = htd_pkg::S_IDLE;
      endcase
   end

   // ---------------------------------------------------------------------
   // Sequencer outputs: handshake and multiplier operand selection.
   // ---------------------------------------------------------------------
   always_comb begin
      req_ready = 1'b0;
      out_load  = 1'b0;
      mul_a     = {8'd0, tick_ff};
      mul_b     = dil_ff;
      unique case (state_ff)
         htd_pkg::S_IDLE: req_ready = 1'b1;
         htd_pkg::S_SCALE: begin
            mul_a = {8'd0, tick_ff};
            mul_b = dil_ff;
         end
         htd_pkg::S_FACTOR: begin
            // The scaled tick never exceeds 32 bits at this point.
            mul_a = acc_ff[31:0];
            mul_b = act_ff ? actuated_boost_ff : decay_rate_ff;
         end
         htd_pkg::S_UPDATE: ;
         htd_pkg::S_RESULT: out_load = out_free;
         default: ;
      endcase
   end

   // Product of a Q16.16 time and a Q8.8 factor, truncated to Q24.16.
   assign mul_prod = {16'd0, mul_a} * {32'd0, mul_b};
   assign mul_q    = mul_prod[htd_pkg::ProdWidth-1:8];

   // Release counter advance with saturation.
   assign release_sum = {1'b0, release_time_ff} + {1'b0, tick_ff};
   assign release_sat = release_sum[htd_pkg::TimeWidth] ? htd_pkg::TimeMax
                                                        : release_sum[htd_pkg::TimeWidth-1:0];

   // Held-time growth, computed one bit wider than the step.
   assign grow_sum = {17'd0, held_time_ff} + {1'b0, acc_ff};

   assign trig_now = held_time_ff >= hold_threshold_ff;

   // ---------------------------------------------------------------------
   // Sequencer state and output register.
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= htd_pkg::S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // ---------------------------------------------------------------------
   // Configuration registers.
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         hold_threshold_ff <= htd_pkg::ThresholdReset;
         decay_delay_ff    <= htd_pkg::DelayReset;
         decay_rate_ff     <= htd_pkg::UnityFactor;
         actuated_boost_ff <= htd_pkg::UnityFactor;
         use_dilation_ff   <= 1'b0;
         one_shot_ff       <= 1'b0;
      end else if (csr_we) begin
         unique case (csr_index)
            htd_pkg::CsrHoldThreshold: hold_threshold_ff <= csr_wdata;
            htd_pkg::CsrDecayDelay:    decay_delay_ff    <= csr_wdata;
            htd_pkg::CsrDecayRate:
               decay_rate_ff <= csr_wdata[htd_pkg::FactorWidth-1:0];
            htd_pkg::CsrActuatedBoost:
               actuated_boost_ff <= csr_wdata[htd_pkg::FactorWidth-1:0];
            htd_pkg::CsrUseDilation:   use_dilation_ff   <= csr_wdata[0];
            htd_pkg::CsrOneShot:       one_shot_ff       <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // ---------------------------------------------------------------------
   // Trigger state: release counter, boost flag, held time and history.
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         held_time_ff     <= '0;
         release_time_ff  <= '0;
         boost_pending_ff <= 1'b0;
         was_triggered_ff <= 1'b0;
      end else begin
         unique case (state_ff)
            htd_pkg::S_FACTOR: begin
               if (act_ff) begin
                  release_time_ff  <= '0;
                  boost_pending_ff <= 1'b0;
               end else begin
                  release_time_ff  <= release_sat;
                  boost_pending_ff <= 1'b1;
               end
            end
            htd_pkg::S_UPDATE: begin
               if (act_ff) begin
                  // Grow and cap at the threshold.
                  if (grow_sum > {17'd0, hold_threshold_ff}) begin
                     held_time_ff <= hold_threshold_ff;
                  end else begin
                     held_time_ff <= grow_sum[htd_pkg::TimeWidth-1:0];
                  end
               end else if (do_decay_ff) begin
                  // Decay, floored at zero.
                  if (acc_ff >= {16'd0, held_time_ff}) begin
                     held_time_ff <= '0;
                  end else begin
                     held_time_ff <= held_time_ff - acc_ff[htd_pkg::TimeWidth-1:0];
                  end
               end
            end
            htd_pkg::S_RESULT: begin
               if (out_free) begin
                  was_triggered_ff <= trig_now;
                  if (trig_now && one_shot_ff) held_time_ff <= '0;
               end
            end
            default: ;
         endcase
      end
   end

   // ---------------------------------------------------------------------
   // Tick latch, working accumulator and result payload (no reset needed).
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         act_ff  <= req_actuated;
         tick_ff <= req_tick_time;
         dil_ff  <= req_dilation;
      end
      unique case (state_ff)
         htd_pkg::S_SCALE: begin
            acc_ff <= use_dilation_ff ? mul_q : {16'd0, tick_ff};
         end
         htd_pkg::S_FACTOR: begin
            // Released ticks always take the decay rate; actuated ticks take
            // the boost only on the first press after a release.
            if (!act_ff || boost_pending_ff) acc_ff <= mul_q;
            do_decay_ff <= release_sat >= decay_delay_ff;
         end
         htd_pkg::S_RESULT: begin
            if (out_load) begin
               if (!trig_now) begin
                  rsp_state_ff <= htd_pkg::TRIG_ONGOING;
               end else if (!was_triggered_ff || !one_shot_ff) begin
                  rsp_state_ff <= htd_pkg::TRIG_TRIGGERED;
               end else begin
                  rsp_state_ff <= htd_pkg::TRIG_NONE;
               end
            end
         end
         default: ;
      endcase
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_trigger_state = rsp_state_ff;

   // ---------------------------------------------------------------------
   // Assertions.
   // ---------------------------------------------------------------------
   a_accept_starts_scale: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff == htd_pkg::S_SCALE))
      else $error("accepted tick did not start the sequencer");

   a_result_loads_output: assert property (@(posedge clock) disable iff (reset)
      (state_ff == htd_pkg::S_RESULT && out_free)
         |=> (rsp_valid_ff && state_ff == htd_pkg::S_IDLE))
      else $error("finished tick did not reach the output register");

   a_stall_holds_result: assert property (@(posedge clock) disable iff (reset)
      (state_ff == htd_pkg::S_RESULT && !out_free)
         |=> (state_ff == htd_pkg::S_RESULT))
      else $error("sequencer left its last step while the output was full");

   a_press_clears_release: assert property (@(posedge clock) disable iff (reset)
      (state_ff == htd_pkg::S_FACTOR && act_ff)
         |=> (release_time_ff == '0 && !boost_pending_ff))
      else $error("actuated tick left release counter or boost flag set");

   a_not_ready_while_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != htd_pkg::S_IDLE) |-> !req_ready)
      else $error("ready raised while a tick is in progress");

endmodule
